// File: rtl/core/vlfo_pkg.sv
// vibrato lfo package: widths, item and register codes, quarter-wave sine table
// no dependencies; used by vibrato_lfo_generator_core
`timescale 1ns / 1ps
`default_nettype none

package vlfo_pkg;

   localparam int SINE_TABLE_BITS = 10;
   localparam int COUNT_BITS      = 32;
   localparam int FRAC_BITS       = 16;
   localparam int QTR_BITS        = SINE_TABLE_BITS - 2;
   localparam int QTR_SIZE        = 1 << QTR_BITS;

   // field and state widths
   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 17;
   localparam int AMOUNT_W = 17;
   localparam int RANGE_W  = 14;
   localparam int PERIOD_W = 16;
   localparam int DELAY_W  = 4;
   localparam int OFFSET_W = 15;
   localparam int SINE_W   = 15;
   localparam int CSR_IDX_W = 3;

   // datapath widths
   localparam int DEN_W   = PERIOD_W + AMOUNT_W;    // period * speed
   localparam int AMP_W   = 30;                      // amount * range, at most 2^29
   localparam int MUL_A_W = AMP_W;
   localparam int MUL_B_W = AMOUNT_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int MAG_SHIFT = 31;
   localparam int MAG_W   = 13;

   // long division: remainder of count<<16, then table index quotient bits
   localparam int NUM_BITS     = COUNT_BITS + FRAC_BITS;
   localparam int DIV_STEPS    = NUM_BITS + SINE_TABLE_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   localparam logic [AMOUNT_W-1:0] Q16_ONE     = AMOUNT_W'(65536);
   localparam logic [RANGE_W-1:0]  RANGE_LIMIT = RANGE_W'(8192);
   localparam logic [VALUE_W-1:0]  DELAY_LIMIT = VALUE_W'(15);
   localparam logic [SINE_W-1:0]   SINE_MAX    = SINE_W'(32767);
   localparam longint unsigned     HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK          = 3'd0,
      FUNC_START         = 3'd1,
      FUNC_SET_AMOUNT    = 3'd2,
      FUNC_SET_SPEED     = 3'd3,
      FUNC_SET_DELAY     = 3'd4,
      FUNC_LOAD_DEFAULTS = 3'd5
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPTH_RANGE    = 3'd0,
      CSR_BASE_PERIOD    = 3'd1,
      CSR_DEFAULT_DELAY  = 3'd2,
      CSR_DEFAULT_AMOUNT = 3'd3,
      CSR_DEFAULT_SPEED  = 3'd4
   } csr_index_type;

   typedef logic [SINE_W-1:0] sine_qtr_type [QTR_SIZE];

   // first quarter of the wave, q2.30 taylor series to x^9, rounded to q15
   // term divisors are the factorial ratios 2*3, 4*5, 6*7 and 8*9
   function automatic sine_qtr_type build_sine_qtr();
      sine_qtr_type    tbl;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned q15;
      int              k;
      for (k = 0; k < QTR_SIZE; k++) begin
         x    = (longint'(k) * HALF_PI_Q30) >> QTR_BITS;
         x2   = (x * x) >> 30;
         term = ((x * x2) >> 30) / 64'd6;
         sum  = x - term;
         term = ((term * x2) >> 30) / 64'd20;
         sum  = sum + term;
         term = ((term * x2) >> 30) / 64'd42;
         sum  = sum - term;
         term = ((term * x2) >> 30) / 64'd72;
         sum  = sum + term;
         q15 = (sum + (64'd1 << 14)) >> 15;
         if (q15 > 64'd32767) begin
            q15 = 64'd32767;
         end
         tbl[k] = SINE_W'(q15);
      end
      return tbl;
   endfunction

   localparam sine_qtr_type SINE_QTR = build_sine_qtr();

endpackage

`default_nettype wire

// File: rtl/core/vibrato_lfo_generator_core.sv
// vibrato lfo generator: per-voice sine lfo with start delay
// depends on vlfo_pkg (widths, codes, sine quarter table)
//
// usage
//   req channel: one word per item (req_func, req_setting_value), taken when
//   req_valid is high and req_stall is low. req_stall stays high from the
//   accepting edge until the sequencer is back in idle.
//   rsp channel: one word per item (rsp_vibrato_offset, rsp_setting_rejected),
//   held in an output register until taken while rsp_stall is low.
//   csr channel: csr_index / csr_wdata, written when csr_valid is high;
//   csr_ready is always high. write only while no item is in flight.
// sequence
//   an item whose offset is forced to zero goes from ST_DEN straight to
//   ST_OUT; any other item passes through two multiplies, 58 steps of
//   the shared restoring divider (48 remainder bits of count<<16 by
//   period*speed, then 10 table index bits), a table read and a scale
//   multiply. the next word can be accepted in the cycle after the result
//   moves to the output register, so a new item is not taken until the
//   last one has handed over its result.
// reset
//   synchronous, active high: registers go to their defaults, speed to 1.0,
//   the sequencer to idle and rsp_valid low.
// stall
//   a result waits in the output register; the next item may be accepted
//   meanwhile, and its result waits in the sequencer until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module vibrato_lfo_generator_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // item input
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [vlfo_pkg::FUNC_W-1:0]         req_func,
   input  wire logic [vlfo_pkg::VALUE_W-1:0]        req_setting_value,
   // result output
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [vlfo_pkg::OFFSET_W-1:0]     rsp_vibrato_offset,
   output logic                                     rsp_setting_rejected,
   // register writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [vlfo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [vlfo_pkg::VALUE_W-1:0]        csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEN,
      ST_AMP,
      ST_DIV,
      ST_SINE,
      ST_SCALE,
      ST_OUT
   } state_type;

   // configuration registers
   logic [vlfo_pkg::RANGE_W-1:0]   depth_range_ff;
   logic [vlfo_pkg::PERIOD_W-1:0]  base_period_ff;
   logic [vlfo_pkg::DELAY_W-1:0]   default_delay_ff;
   logic [vlfo_pkg::AMOUNT_W-1:0]  default_amount_ff;
   logic [vlfo_pkg::AMOUNT_W-1:0]  default_speed_ff;

   // voice state
   logic [vlfo_pkg::COUNT_BITS-1:0] frame_count_ff, frame_count_in;
   logic [vlfo_pkg::AMOUNT_W-1:0]   live_amount_ff, live_amount_in;
   logic [vlfo_pkg::AMOUNT_W-1:0]   live_speed_ff, live_speed_in;
   logic [vlfo_pkg::DELAY_W-1:0]    live_delay_ff, live_delay_in;
   logic                            rejected_ff, rejected_in;

   // sequencer and datapath
   state_type                             state_ff, state_in;
   logic [vlfo_pkg::DEN_W-1:0]            den_ff, den_in;
   logic [vlfo_pkg::AMP_W-1:0]            amp_ff, amp_in;
   logic [vlfo_pkg::DEN_W-1:0]            rem_ff, rem_in;
   logic [vlfo_pkg::NUM_BITS-1:0]         num_ff, num_in;
   logic [vlfo_pkg::SINE_TABLE_BITS-1:0]  idx_ff, idx_in;
   logic [vlfo_pkg::DIV_CNT_BITS-1:0]     step_ff, step_in;
   logic [vlfo_pkg::SINE_W-1:0]           sine_mag_ff, sine_mag_in;
   logic                                  sine_neg_ff, sine_neg_in;
   logic signed [vlfo_pkg::OFFSET_W-1:0]  offset_ff, offset_in;

   // output register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [vlfo_pkg::OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic                                  rsp_rejected_ff, rsp_rejected_in;

   // shared multiplier
   logic [vlfo_pkg::MUL_A_W-1:0] mul_a;
   logic [vlfo_pkg::MUL_B_W-1:0] mul_b;
   logic [vlfo_pkg::PROD_W-1:0]  mul_p;

   // shared divider step
   logic                           div_bit;
   logic [vlfo_pkg::DEN_W:0]       div_trial;
   logic                           div_ge;
   logic [vlfo_pkg::DEN_W-1:0]     div_rem;
   logic                           rem_phase;

   // item decode
   logic                           accept;
   logic [vlfo_pkg::AMOUNT_W-1:0]  amount_value;
   logic [vlfo_pkg::AMOUNT_W-1:0]  speed_value;
   logic                           amount_bad;
   logic                           speed_bad;
   logic [vlfo_pkg::RANGE_W-1:0]   range_sat;
   logic                           out_free;

   // sine lookup
   logic [1:0]                     quad;
   logic [vlfo_pkg::QTR_BITS:0]    qtr_ref;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_vibrato_offset   = rsp_offset_ff;
   assign rsp_setting_rejected = rsp_rejected_ff;

   // load-defaults uses the default registers, set items the payload
   assign amount_value = (req_func == vlfo_pkg::FUNC_LOAD_DEFAULTS) ?
                         default_amount_ff : req_setting_value;
   assign speed_value  = (req_func == vlfo_pkg::FUNC_LOAD_DEFAULTS) ?
                         default_speed_ff : req_setting_value;
   assign amount_bad   = amount_value > vlfo_pkg::Q16_ONE;
   assign speed_bad    = speed_value > vlfo_pkg::Q16_ONE;

   assign range_sat = (depth_range_ff > vlfo_pkg::RANGE_LIMIT) ?
                      vlfo_pkg::RANGE_LIMIT : depth_range_ff;

   // one multiplier serves period*speed, amount*range and the final scale
   always_comb begin
      case (state_ff)
         ST_DEN: begin
            mul_a = vlfo_pkg::MUL_A_W'(base_period_ff);
            mul_b = live_speed_ff;
         end
         ST_AMP: begin
            mul_a = vlfo_pkg::MUL_A_W'(live_amount_ff);
            mul_b = vlfo_pkg::MUL_B_W'(range_sat);
         end
         default: begin
            mul_a = amp_ff;
            mul_b = vlfo_pkg::MUL_B_W'(sine_mag_ff);
         end
      endcase
   end

   assign mul_p = vlfo_pkg::PROD_W'(mul_a) * vlfo_pkg::PROD_W'(mul_b);

   // restoring divide step: remainder bits first, then quotient bits
   assign rem_phase = step_ff < vlfo_pkg::DIV_CNT_BITS'(vlfo_pkg::NUM_BITS);
   assign div_bit   = rem_phase ? num_ff[vlfo_pkg::NUM_BITS-1] : 1'b0;
   assign div_trial = {rem_ff, div_bit};
   assign div_ge    = div_trial >= {1'b0, den_ff};
   assign div_rem   = div_ge ? vlfo_pkg::DEN_W'(div_trial - {1'b0, den_ff}) :
                               div_trial[vlfo_pkg::DEN_W-1:0];

   // quarter-wave fold of the table index
   assign quad    = idx_ff[vlfo_pkg::SINE_TABLE_BITS-1 -: 2];
   assign qtr_ref = quad[0] ?
      (vlfo_pkg::QTR_BITS+1)'(vlfo_pkg::QTR_SIZE) - {1'b0, idx_ff[vlfo_pkg::QTR_BITS-1:0]} :
      {1'b0, idx_ff[vlfo_pkg::QTR_BITS-1:0]};

   always_comb begin
      state_in        = state_ff;
      frame_count_in  = frame_count_ff;
      live_amount_in  = live_amount_ff;
      live_speed_in   = live_speed_ff;
      live_delay_in   = live_delay_ff;
      rejected_in     = rejected_ff;
      den_in          = den_ff;
      amp_in          = amp_ff;
      rem_in          = rem_ff;
      num_in          = num_ff;
      idx_in          = idx_ff;
      step_in         = step_ff;
      sine_mag_in     = sine_mag_ff;
      sine_neg_in     = sine_neg_ff;
      offset_in       = offset_ff;
      rsp_offset_in   = rsp_offset_ff;
      rsp_rejected_in = rsp_rejected_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_DEN;
               rejected_in = 1'b0;
               case (req_func)
                  vlfo_pkg::FUNC_TICK: begin
                     // saturating frame counter, frozen while amount is zero
                     if (live_amount_ff != '0 && frame_count_ff != '1) begin
                        frame_count_in = frame_count_ff + 1'b1;
                     end
                  end
                  vlfo_pkg::FUNC_START: begin
                     frame_count_in = '0;
                     live_delay_in  = default_delay_ff;
                  end
                  vlfo_pkg::FUNC_SET_AMOUNT: begin
                     rejected_in = amount_bad;
                     if (!amount_bad) begin
                        if ((live_amount_ff == '0) != (amount_value == '0)) begin
                           frame_count_in = '0;
                        end
                        live_amount_in = amount_value;
                     end
                  end
                  vlfo_pkg::FUNC_SET_SPEED: begin
                     rejected_in = speed_bad;
                     if (!speed_bad) begin
                        live_speed_in = speed_value;
                     end
                  end
                  vlfo_pkg::FUNC_SET_DELAY: begin
                     if (req_setting_value > vlfo_pkg::DELAY_LIMIT) begin
                        rejected_in = 1'b1;
                     end else begin
                        live_delay_in = req_setting_value[vlfo_pkg::DELAY_W-1:0];
                     end
                  end
                  vlfo_pkg::FUNC_LOAD_DEFAULTS: begin
                     rejected_in = amount_bad || speed_bad;
                     if (!amount_bad) begin
                        if ((live_amount_ff == '0) != (amount_value == '0)) begin
                           frame_count_in = '0;
                        end
                        live_amount_in = amount_value;
                     end
                     if (!speed_bad) begin
                        live_speed_in = speed_value;
                     end
                  end
                  default: begin
                     // unused codes leave the voice alone
                  end
               endcase
            end
         end
         ST_DEN: begin
            den_in  = mul_p[vlfo_pkg::DEN_W-1:0];
            rem_in  = '0;
            step_in = '0;
            idx_in  = '0;
            num_in  = {frame_count_ff - vlfo_pkg::COUNT_BITS'(live_delay_ff),
                       vlfo_pkg::FRAC_BITS'(0)};
            if (live_amount_ff == '0 || live_speed_ff == '0 || base_period_ff == '0 ||
                frame_count_ff < vlfo_pkg::COUNT_BITS'(live_delay_ff)) begin
               offset_in = '0;
               state_in  = ST_OUT;
            end else begin
               state_in  = ST_AMP;
            end
         end
         ST_AMP: begin
            amp_in   = mul_p[vlfo_pkg::AMP_W-1:0];
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = div_rem;
            num_in  = num_ff << 1;
            step_in = step_ff + 1'b1;
            if (!rem_phase) begin
               idx_in = {idx_ff[vlfo_pkg::SINE_TABLE_BITS-2:0], div_ge};
            end
            if (step_ff == vlfo_pkg::DIV_CNT_BITS'(vlfo_pkg::DIV_STEPS - 1)) begin
               state_in = ST_SINE;
            end
         end
         ST_SINE: begin
            // the quarter peak sits just past the table and clamps to full scale
            if (qtr_ref[vlfo_pkg::QTR_BITS]) begin
               sine_mag_in = vlfo_pkg::SINE_MAX;
            end else begin
               sine_mag_in = vlfo_pkg::SINE_QTR[qtr_ref[vlfo_pkg::QTR_BITS-1:0]];
            end
            sine_neg_in = quad[1];
            state_in    = ST_SCALE;
         end
         ST_SCALE: begin
            // magnitude truncates, sign applied after: rounds toward zero
            if (sine_neg_ff) begin
               offset_in = vlfo_pkg::OFFSET_W'(0) -
                  vlfo_pkg::OFFSET_W'(mul_p[vlfo_pkg::MAG_SHIFT +: vlfo_pkg::MAG_W]);
            end else begin
               offset_in = vlfo_pkg::OFFSET_W'(mul_p[vlfo_pkg::MAG_SHIFT +: vlfo_pkg::MAG_W]);
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hand the word over once the output register is free
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_offset_in   = offset_ff;
               rsp_rejected_in = rejected_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         frame_count_ff    <= '0;
         live_amount_ff    <= '0;
         live_speed_ff     <= vlfo_pkg::Q16_ONE;
         live_delay_ff     <= '0;
         depth_range_ff    <= '0;
         base_period_ff    <= '0;
         default_delay_ff  <= '0;
         default_amount_ff <= '0;
         default_speed_ff  <= vlfo_pkg::Q16_ONE;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         frame_count_ff <= frame_count_in;
         live_amount_ff <= live_amount_in;
         live_speed_ff  <= live_speed_in;
         live_delay_ff  <= live_delay_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               vlfo_pkg::CSR_DEPTH_RANGE: begin
                  depth_range_ff <= csr_wdata[vlfo_pkg::RANGE_W-1:0];
               end
               vlfo_pkg::CSR_BASE_PERIOD: begin
                  base_period_ff <= csr_wdata[vlfo_pkg::PERIOD_W-1:0];
               end
               vlfo_pkg::CSR_DEFAULT_DELAY: begin
                  default_delay_ff <= csr_wdata[vlfo_pkg::DELAY_W-1:0];
               end
               vlfo_pkg::CSR_DEFAULT_AMOUNT: begin
                  default_amount_ff <= csr_wdata[vlfo_pkg::AMOUNT_W-1:0];
               end
               vlfo_pkg::CSR_DEFAULT_SPEED: begin
                  default_speed_ff <= csr_wdata[vlfo_pkg::AMOUNT_W-1:0];
               end
               default: begin
                  // writes past the register list are dropped
               end
            endcase
         end
      end
   end

   // datapath payload, no reset needed
   always_ff @(posedge clock) begin
      rejected_ff     <= rejected_in;
      den_ff          <= den_in;
      amp_ff          <= amp_in;
      rem_ff          <= rem_in;
      num_ff          <= num_in;
      idx_ff          <= idx_in;
      step_ff         <= step_in;
      sine_mag_ff     <= sine_mag_in;
      sine_neg_ff     <= sine_neg_in;
      offset_ff       <= offset_in;
      rsp_offset_ff   <= rsp_offset_in;
      rsp_rejected_ff <= rsp_rejected_in;
   end

   // the counter only runs while the amount is nonzero, and every crossing
   // into zero clears it
   a_count_idle_at_zero_amount: assert property (
      @(posedge clock) disable iff (reset)
      (live_amount_ff == '0) |-> (frame_count_ff == '0))
      else $error("frame count nonzero while amount is zero");

   // range checks keep live settings at or below 1.0
   a_settings_in_range: assert property (
      @(posedge clock) disable iff (reset)
      (live_amount_ff <= vlfo_pkg::Q16_ONE) && (live_speed_ff <= vlfo_pkg::Q16_ONE))
      else $error("live amount or speed above 1.0");

   // restoring divider keeps its partial remainder below the divisor
   a_div_rem_bound: assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");

   // an accepted item always starts the sequencer
   a_accept_starts: assert property (
      @(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DEN))
      else $error("accepted word did not start the sequencer");

endmodule

`default_nettype wire

// File: test/vlfo_checker.sv
// result checker for vibrato_lfo_generator_core: predicts each rsp word from the req words
// depends on vlfo_pkg for widths, item codes and register indexes
`timescale 1ns / 1ps

module vlfo_checker
   import vlfo_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_stall,
   input  wire logic [FUNC_W-1:0]          req_func,
   input  wire logic [VALUE_W-1:0]         req_setting_value,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire logic signed [OFFSET_W-1:0] rsp_vibrato_offset,
   input  wire logic                       rsp_setting_rejected,
   input  wire logic                       csr_valid,
   input  wire logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [VALUE_W-1:0]         csr_wdata,
   output int                              mismatch_count,
   output int                              pending_count,
   output int                              words_seen,
   output int                              nonzero_seen,
   output int                              rejected_seen
);

   typedef logic signed [OFFSET_W-1:0] offset_type;

   typedef struct {
      offset_type offset;
      logic       rejected;
   } lfo_word_type;

   lfo_word_type expected_words[$];

   // register copies
   logic [RANGE_W-1:0]    reg_range;
   logic [PERIOD_W-1:0]   reg_period;
   logic [DELAY_W-1:0]    reg_delay;
   logic [AMOUNT_W-1:0]   reg_def_amount;
   logic [AMOUNT_W-1:0]   reg_def_speed;

   // voice state
   logic [COUNT_BITS-1:0] voice_frames;
   logic [AMOUNT_W-1:0]   voice_amount;
   logic [AMOUNT_W-1:0]   voice_speed;
   logic [DELAY_W-1:0]    voice_delay;

   int fails;
   int seen;
   int nonzero;
   int rejects;

   task automatic report(input string msg);
      if (fails < 30) begin
         $display("%0t mismatch: %s", $time, msg);
      end
      fails++;
   endtask

   // q1.15 sine of a table slot, quarter-wave taylor series in q2.30
   function automatic int sine_q15(input longint unsigned slot);
      longint unsigned quadrant;
      longint unsigned k;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned divisor;
      longint unsigned q15;
      int              n;
      quadrant = (slot >> QTR_BITS) & 64'd3;
      k        = slot & (QTR_SIZE - 1);
      if (quadrant[0]) begin
         k = QTR_SIZE - k;
      end
      x    = (k * HALF_PI_Q30) >> QTR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (n = 1; n <= 4; n++) begin
         divisor = (2 * n) * (2 * n + 1);
         term    = ((term * x2) >> 30) / divisor;
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      q15 = (sum + (64'd1 << 14)) >> 15;
      if (q15 > 64'd32767) begin
         q15 = 64'd32767;
      end
      return (quadrant >= 2) ? -int'(q15) : int'(q15);
   endfunction

   function automatic offset_type predict_offset();
      longint unsigned span;
      longint unsigned period;
      longint unsigned speed;
      longint unsigned lag;
      longint unsigned rem;
      longint unsigned slot;
      longint unsigned clipped;
      longint unsigned amount;
      longint unsigned level;
      longint unsigned mag;
      int              s;
      if (voice_amount == '0 || voice_speed == '0 || reg_period == '0 ||
          voice_frames < voice_delay) begin
         return '0;
      end
      clipped = (reg_range > RANGE_LIMIT) ? RANGE_LIMIT : reg_range;
      period  = reg_period;
      speed   = voice_speed;
      span    = period * speed;
      lag     = voice_frames - voice_delay;
      rem     = ((lag % span) << FRAC_BITS) % span;
      slot    = (rem << SINE_TABLE_BITS) / span;
      s       = sine_q15(slot);
      level   = (s < 0) ? -s : s;
      amount  = voice_amount;
      mag     = (amount * clipped * level) >> MAG_SHIFT;
      return (s < 0) ? -offset_type'(mag) : offset_type'(mag);
   endfunction

   // amount change into or out of zero restarts the frame count
   function automatic bit take_amount(input logic [VALUE_W-1:0] value);
      if (value > Q16_ONE) begin
         return 1'b1;
      end
      if ((voice_amount == '0) != (value == '0)) begin
         voice_frames = '0;
      end
      voice_amount = value[AMOUNT_W-1:0];
      return 1'b0;
   endfunction

   function automatic bit take_speed(input logic [VALUE_W-1:0] value);
      if (value > Q16_ONE) begin
         return 1'b1;
      end
      voice_speed = value[AMOUNT_W-1:0];
      return 1'b0;
   endfunction

   function automatic lfo_word_type apply_item(input logic [FUNC_W-1:0] code,
                                               input logic [VALUE_W-1:0] value);
      lfo_word_type word;
      bit           bad_amount;
      bit           bad_speed;
      word.rejected = 1'b0;
      case (code)
         FUNC_TICK: begin
            if (voice_amount != '0 && voice_frames != '1) begin
               voice_frames = voice_frames + 1'b1;
            end
         end
         FUNC_START: begin
            voice_frames = '0;
            voice_delay  = reg_delay;
         end
         FUNC_SET_AMOUNT: word.rejected = take_amount(value);
         FUNC_SET_SPEED:  word.rejected = take_speed(value);
         FUNC_SET_DELAY: begin
            if (value > DELAY_LIMIT) begin
               word.rejected = 1'b1;
            end else begin
               voice_delay = value[DELAY_W-1:0];
            end
         end
         FUNC_LOAD_DEFAULTS: begin
            bad_amount    = take_amount(reg_def_amount);
            bad_speed     = take_speed(reg_def_speed);
            word.rejected = bad_amount || bad_speed;
         end
         default: ;
      endcase
      word.offset = predict_offset();
      return word;
   endfunction

   always @(posedge clock) begin : watch
      lfo_word_type want;
      if (reset) begin
         reg_range      = '0;
         reg_period     = '0;
         reg_delay      = '0;
         reg_def_amount = '0;
         reg_def_speed  = Q16_ONE;
         voice_frames   = '0;
         voice_amount   = '0;
         voice_speed    = Q16_ONE;
         voice_delay    = '0;
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEPTH_RANGE:    reg_range      = csr_wdata[RANGE_W-1:0];
               CSR_BASE_PERIOD:    reg_period     = csr_wdata[PERIOD_W-1:0];
               CSR_DEFAULT_DELAY:  reg_delay      = csr_wdata[DELAY_W-1:0];
               CSR_DEFAULT_AMOUNT: reg_def_amount = csr_wdata[AMOUNT_W-1:0];
               CSR_DEFAULT_SPEED:  reg_def_speed  = csr_wdata[AMOUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (rsp_vibrato_offset != '0) nonzero++;
            if (rsp_setting_rejected) rejects++;
            if (expected_words.size() == 0) begin
               report($sformatf("word with nothing expected, offset %0d rejected %0b",
                                rsp_vibrato_offset, rsp_setting_rejected));
            end else begin
               want = expected_words.pop_front();
               if (rsp_vibrato_offset !== want.offset) begin
                  report($sformatf("word %0d offset %0d, expected %0d",
                                   seen, rsp_vibrato_offset, want.offset));
               end
               if (rsp_setting_rejected !== want.rejected) begin
                  report($sformatf("word %0d rejected %0b, expected %0b",
                                   seen, rsp_setting_rejected, want.rejected));
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_words.push_back(apply_item(req_func, req_setting_value));
         end
      end
      mismatch_count <= fails;
      pending_count  <= expected_words.size();
      words_seen     <= seen;
      nonzero_seen   <= nonzero;
      rejected_seen  <= rejects;
   end

endmodule

// File: test/tb.sv
// top-level testbench for vibrato_lfo_generator_core: clock, reset, stimulus and verdict
// depends on vlfo_pkg, vibrato_lfo_generator_core and vlfo_checker
`timescale 1ns / 1ps

module tb;
   import vlfo_pkg::*;

   // func codes the block has no operation for
   localparam logic [FUNC_W-1:0]  FUNC_SPARE_A = FUNC_W'(6);
   localparam logic [FUNC_W-1:0]  FUNC_SPARE_B = FUNC_W'(7);

   localparam logic [VALUE_W-1:0] VALUE_ALL_ONES = '1;
   localparam logic [VALUE_W-1:0] Q16_OVER       = Q16_ONE + 1'b1;

   localparam int PHASES          = 9;
   localparam int ITEMS_PER_PHASE = 210;
   localparam int HOLD_CYCLES     = 300;    // long receiver hold-off
   localparam int WATCHDOG_LIMIT  = 3000;   // cycles with no handshake at all
   localparam int DRAIN_CYCLES    = 80;     // longer than one item takes from accept to result

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [FUNC_W-1:0]          req_func;
   logic [VALUE_W-1:0]         req_setting_value;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [OFFSET_W-1:0] rsp_vibrato_offset;
   logic                       rsp_setting_rejected;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [VALUE_W-1:0]         csr_wdata;

   int mismatch_count;
   int pending_count;
   int words_seen;
   int nonzero_seen;
   int rejected_seen;

   int items_sent;
   int settings_done;
   bit idle_enable;     // random gaps and stalls allowed
   bit hold_request;    // ask the receiver for one long hold-off

   vibrato_lfo_generator_core u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_setting_value    (req_setting_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_vibrato_offset   (rsp_vibrato_offset),
      .rsp_setting_rejected (rsp_setting_rejected),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // watches all three channels, predicts every rsp word and compares it
   vlfo_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_setting_value    (req_setting_value),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_vibrato_offset   (rsp_vibrato_offset),
      .rsp_setting_rejected (rsp_setting_rejected),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .mismatch_count       (mismatch_count),
      .pending_count        (pending_count),
      .words_seen           (words_seen),
      .nonzero_seen         (nonzero_seen),
      .rejected_seen        (rejected_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: short random stall bursts, or one long hold-off on request
   initial begin : rsp_side
      int burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall    = 1'b0;
            hold_request = 1'b0;
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            burst     = $urandom_range(1, 5);
            repeat (burst) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // no handshake on any channel for too long means the block is hung
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("timeout: no handshake for %0d cycles, %0d words outstanding",
               WATCHDOG_LIMIT, pending_count);
      $display("FAIL vibrato_lfo_generator_core");
      $finish;
   end

   // one req word; valid stays high from word to word, gaps only between
   task automatic send_item(input logic [FUNC_W-1:0] code, input logic [VALUE_W-1:0] value);
      int gap;
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         gap       = $urandom_range(1, 5);
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_func          = code;
      req_setting_value = value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // stop offering and wait until every expected word has come back
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [VALUE_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // only called with the block idle
   task automatic write_settings(input logic [VALUE_W-1:0] range_val,
                                 input logic [VALUE_W-1:0] period_val,
                                 input logic [VALUE_W-1:0] delay_val,
                                 input logic [VALUE_W-1:0] amount_val,
                                 input logic [VALUE_W-1:0] speed_val);
      write_register(CSR_DEPTH_RANGE, range_val);
      write_register(CSR_BASE_PERIOD, period_val);
      write_register(CSR_DEFAULT_DELAY, delay_val);
      write_register(CSR_DEFAULT_AMOUNT, amount_val);
      write_register(CSR_DEFAULT_SPEED, speed_val);
      @(negedge clock);
      csr_valid = 1'b0;
      settings_done++;
   endtask

   // q1.16 amount or speed: mostly legal, with zero, one and over-range mixed in
   function automatic logic [VALUE_W-1:0] pick_q16(input bit is_speed);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return Q16_ONE;
         2:       return VALUE_W'($urandom_range(Q16_OVER, VALUE_ALL_ONES));
         3:       return VALUE_W'($urandom_range(0, VALUE_ALL_ONES));
         4:       return VALUE_W'($urandom_range(1, 255));
         // small speeds make the phase sweep quickly over the table
         default: return is_speed ? VALUE_W'($urandom_range(1, Q16_ONE) >> $urandom_range(0, 10))
                                  : VALUE_W'($urandom_range(1, Q16_ONE));
      endcase
   endfunction

   task automatic send_random_item();
      int                 roll;
      logic [FUNC_W-1:0]  code;
      logic [VALUE_W-1:0] value;
      roll  = $urandom_range(0, 99);
      value = VALUE_W'($urandom_range(0, VALUE_ALL_ONES));
      // ticks dominate so the frame count gets well past the delay
      if (roll < 45) begin
         code = FUNC_TICK;
      end else if (roll < 52) begin
         code = FUNC_START;
      end else if (roll < 66) begin
         code  = FUNC_SET_AMOUNT;
         value = pick_q16(1'b0);
      end else if (roll < 77) begin
         code  = FUNC_SET_SPEED;
         value = pick_q16(1'b1);
      end else if (roll < 85) begin
         code = FUNC_SET_DELAY;
         if ($urandom_range(0, 4) != 0) value = VALUE_W'($urandom_range(0, 15));
      end else if (roll < 92) begin
         code = FUNC_LOAD_DEFAULTS;
      end else if (roll < 96) begin
         code = FUNC_SPARE_A;
      end else begin
         code = FUNC_SPARE_B;
      end
      send_item(code, value);
   endtask

   // extremes, every item kind and each corner of the vibrato rules
   task automatic run_directed();
      send_item(FUNC_TICK, VALUE_ALL_ONES);        // amount zero: count holds
      send_item(FUNC_SET_AMOUNT, Q16_ONE);         // zero to nonzero clears count
      send_item(FUNC_TICK, '0);
      send_item(FUNC_TICK, '0);
      send_item(FUNC_SET_SPEED, '0);               // zero speed forces zero
      send_item(FUNC_SET_SPEED, Q16_OVER);         // just over range
      send_item(FUNC_SET_SPEED, Q16_ONE);
      send_item(FUNC_SET_AMOUNT, VALUE_ALL_ONES);  // far over range
      send_item(FUNC_SET_AMOUNT, Q16_OVER);
      send_item(FUNC_SET_DELAY, 17'd16);           // one over the delay limit
      send_item(FUNC_SET_DELAY, 17'd15);
      send_item(FUNC_START, '0);                   // reload default delay
      send_item(FUNC_TICK, '0);                    // still inside the delay
      send_item(FUNC_TICK, '0);
      send_item(FUNC_TICK, '0);
      send_item(FUNC_SET_AMOUNT, '0);              // nonzero to zero clears count
      send_item(FUNC_TICK, '0);
      send_item(FUNC_LOAD_DEFAULTS, '0);
      send_item(FUNC_TICK, '0);
      send_item(FUNC_SPARE_A, VALUE_ALL_ONES);
      send_item(FUNC_SPARE_B, VALUE_ALL_ONES);
      send_item(FUNC_SET_AMOUNT, 17'd1);           // smallest amount
      send_item(FUNC_SET_DELAY, '0);
      send_item(FUNC_TICK, '0);
      send_item(FUNC_TICK, '0);
   endtask

   initial begin : stimulus
      int phase;
      int i;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_func          = FUNC_TICK;
      req_setting_value = '0;
      csr_valid         = 1'b0;
      csr_index         = CSR_DEPTH_RANGE;
      csr_wdata         = '0;
      idle_enable       = 1'b1;
      hold_request      = 1'b0;
      items_sent        = 0;
      settings_done     = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         // the final phase runs with no gaps or stalls
         idle_enable = (phase != PHASES - 1);
         drain();
         case (phase)
            0: write_settings(17'd8192, 17'd16, 17'd2, Q16_ONE, Q16_ONE);
            // range above its limit, longest period, a default amount that gets rejected
            1: write_settings(VALUE_ALL_ONES, 17'd65535, 17'd15, VALUE_ALL_ONES, '0);
            // zero period forces every offset to zero
            2: write_settings('0, '0, '0, '0, Q16_OVER);
            default: write_settings(
               ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom_range(0, VALUE_ALL_ONES))
                                           : VALUE_W'($urandom_range(0, 8192)),
               ($urandom_range(0, 7) == 0) ? VALUE_W'($urandom_range(0, 65535))
                                           : VALUE_W'($urandom_range(1, 200)),
               VALUE_W'($urandom_range(0, VALUE_ALL_ONES)),
               pick_q16(1'b0),
               pick_q16(1'b1));
         endcase
         if (phase == 0) run_directed();
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            // receiver holds off while req words keep coming: block fills up
            if (phase == 4 && i == 30) hold_request = 1'b1;
            // sender pauses mid-phase until the block is empty
            if (phase == 5 && i == 100) drain();
            send_random_item();
         end
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d req words over %0d register settings, %0d rsp words",
               items_sent, settings_done, words_seen);
      $display("%0d nonzero offsets, %0d rejected settings, %0d mismatches",
               nonzero_seen, rejected_seen, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("PASS vibrato_lfo_generator_core");
      end else begin
         $display("FAIL vibrato_lfo_generator_core");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/vlfo_pkg.sv
rtl/core/vibrato_lfo_generator_core.sv
test/vlfo_checker.sv
test/tb.sv
